FILE: sv/bitmap_block_allocator_defines.svh
// Assertion macros used by the allocator datapath.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: sv/bba_pkg.sv
// Shared constants, types and helper functions of the block allocator.
package bba_pkg;

    localparam int BLOCK_COUNT    = 4096;
    localparam int WORD_BITS      = 32;
    localparam int MAP_WORDS      = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int RESERVED_RESET = 18;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 12;
    localparam int RES_W  = 12;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(BLOCK_COUNT + 1);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = $clog2(MAP_WORDS);
    localparam int PTR_W  = $clog2(MAP_WORDS + 1);

    // Request opcodes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic fmt_step;
        logic fmt_done;
        logic alloc_commit;
        logic alloc_full;
        logic free_commit;
        logic free_bad;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic free_range_bad;
        logic free_bit_set;
        logic fmt_last;
    } t_dp_stat;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_find;

    // Lowest clear bit of a map word
    function automatic t_find lowest_zero(input logic [WORD_BITS-1:0] w);
        t_find f;
        f.found = 1'b0;
        f.pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                f.found = 1'b1;
                f.pos   = BIT_W'(i);
            end
        end
        return f;
    endfunction

    // Mask with the n lowest bits set
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [BIT_W-1:0] n);
        return (WORD_BITS'(1) << n) - WORD_BITS'(1);
    endfunction

endpackage

FILE: sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bba_datapath.sv
// Allocator datapath: used map RAM, scan pointer, free count and result registers.
`include "bitmap_block_allocator_defines.svh"

module bba_datapath
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [RES_W-1:0]  i_cfg_res,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [IDX_W-1:0]  i_block_index,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_granted_index,
    output logic [CNT_W-1:0]  o_free_count
);

    localparam logic [CNT_W-1:0] TOTAL_C = CNT_W'(BLOCK_COUNT);
    localparam logic [PTR_W-1:0] WORDS_C = PTR_W'(MAP_WORDS);
    localparam logic [ADDR_W-1:0] LAST_C = ADDR_W'(MAP_WORDS - 1);

    logic [RES_W-1:0]  r_res;
    logic [CNT_W-1:0]  r_fmt_res;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  r_ptr;
    logic [ADDR_W-1:0] r_dptr;
    logic              r_dvalid;
    logic [IDX_W-1:0]  r_idx;
    logic [STAT_W-1:0] r_rstat;
    logic [IDX_W-1:0]  r_rgrant;
    logic [STAT_W-1:0] r_ostat;
    logic [IDX_W-1:0]  r_ogrant;
    logic [CNT_W-1:0]  r_ocount;

    logic [CNT_W-1:0]     eff_res;
    logic [PTR_W-1:0]     start_word;
    logic [PTR_W-1:0]     fmt_word;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] scan_word;
    logic [WORD_BITS-1:0] fmt_data;
    t_find                find;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;

    // Reserved count clamped to the map size
    assign eff_res    = (CNT_W'(r_res) > TOTAL_C) ? TOTAL_C : CNT_W'(r_res);
    assign start_word = PTR_W'(eff_res >> BIT_W);
    assign fmt_word   = PTR_W'(r_fmt_res >> BIT_W);

    // Scan: reserved bits of the first word count as used
    always_comb begin
        scan_word = rdata;
        if (PTR_W'(r_dptr) == start_word) begin
            scan_word = rdata | low_mask(eff_res[BIT_W-1:0]);
        end
    end
    assign find = lowest_zero(scan_word);

    // Format word: whole words below the reserve, partial word at its edge
    always_comb begin
        if (r_ptr < fmt_word) begin
            fmt_data = '1;
        end else if (r_ptr == fmt_word) begin
            fmt_data = low_mask(r_fmt_res[BIT_W-1:0]);
        end else begin
            fmt_data = '0;
        end
    end

    // Map write port
    always_comb begin
        we    = i_cmd.fmt_step | i_cmd.alloc_commit | i_cmd.free_commit;
        waddr = i_cmd.fmt_step ? r_ptr[ADDR_W-1:0] : r_dptr;
        if (i_cmd.fmt_step) begin
            wdata = fmt_data;
        end else if (i_cmd.alloc_commit) begin
            wdata = rdata | (WORD_BITS'(1) << find.pos);
        end else begin
            wdata = rdata & ~(WORD_BITS'(1) << r_idx[BIT_W-1:0]);
        end
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // Status toward the controller
    always_comb begin
        o_stat.scan_hit       = r_dvalid & find.found;
        o_stat.scan_end       = (r_dvalid & ~find.found & (r_dptr == LAST_C))
                              | (~r_dvalid & (r_ptr >= WORDS_C));
        o_stat.free_range_bad = (CNT_W'(r_idx) < eff_res) | (CNT_W'(r_idx) >= TOTAL_C);
        o_stat.free_bit_set   = r_dvalid & rdata[r_idx[BIT_W-1:0]];
        o_stat.fmt_last       = (r_ptr == PTR_W'(MAP_WORDS - 1));
    end

    // Control registers: reserve, pointers, count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res     <= RES_W'(RESERVED_RESET);
            r_fmt_res <= CNT_W'(RESERVED_RESET);
            r_count   <= CNT_W'(BLOCK_COUNT - RESERVED_RESET);
            r_ptr     <= '0;
            r_dvalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_res <= i_cfg_res;
            end
            if (i_cmd.accept) begin
                r_dvalid <= 1'b0;
                if (i_opcode == OP_ALLOC) begin
                    r_ptr <= start_word;
                end else if (i_opcode == OP_FREE) begin
                    r_ptr <= PTR_W'(i_block_index >> BIT_W);
                end else begin
                    r_ptr     <= '0;
                    r_fmt_res <= eff_res;
                end
            end else if (i_cmd.fmt_step) begin
                r_ptr <= r_ptr + PTR_W'(1);
            end else if (i_cmd.rd_en) begin
                if (r_ptr < WORDS_C) begin
                    r_dvalid <= 1'b1;
                    r_ptr    <= r_ptr + PTR_W'(1);
                end else begin
                    r_dvalid <= 1'b0;
                end
            end
            if (i_cmd.fmt_done) begin
                r_count <= TOTAL_C - r_fmt_res;
            end else if (i_cmd.alloc_commit && r_count != '0) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.free_commit && r_count < TOTAL_C) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Payload registers: request, pending result, output item
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_dptr <= r_ptr[ADDR_W-1:0];
        end
        if (i_cmd.accept) begin
            r_idx    <= i_block_index;
            r_rstat  <= STAT_OK;
            r_rgrant <= '0;
        end
        if (i_cmd.alloc_commit) begin
            r_rgrant <= IDX_W'({r_dptr, find.pos});
        end
        if (i_cmd.alloc_full) begin
            r_rstat <= STAT_FULL;
        end
        if (i_cmd.free_bad) begin
            r_rstat <= STAT_BAD;
        end
        if (i_cmd.load_out) begin
            r_ostat  <= r_rstat;
            r_ogrant <= r_rgrant;
            r_ocount <= r_count;
        end
    end

    assign o_status        = r_ostat;
    assign o_granted_index = r_ogrant;
    assign o_free_count    = r_ocount;

    // The count stays within the map size, allocate and free commit only with room, format resets it
    `BBA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= TOTAL_C)
    `BBA_ASSERT_NOW(a_alloc_has_free, i_clk, i_rst_n, i_cmd.alloc_commit, r_count != '0)
    `BBA_ASSERT_NOW(a_free_has_room, i_clk, i_rst_n, i_cmd.free_commit, r_count < TOTAL_C)
    `BBA_ASSERT_NEXT(a_fmt_count, i_clk, i_rst_n, i_cmd.fmt_done,
        r_count == TOTAL_C - $past(r_fmt_res))

endmodule

FILE: sv/bba_ctrl.sv
// Allocator controller: sequences init sweep, format, scan, free and result handoff.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_cfg_ready,
    input  logic [OP_W-1:0] i_opcode,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output t_dp_cmd         o_cmd,
    input  t_dp_stat        i_stat
);

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_FMT      = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_FREE_RD  = 3'd4;
    localparam logic [2:0] S_FREE_CHK = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_rsp_valid;
    logic       n_rsp_valid;
    logic       out_free;

    assign out_free    = ~r_rsp_valid | i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);

    // Reserve writes only with no request being worked on or taken
    assign o_cfg_ready = ((r_state == S_IDLE) & ~i_req_valid) | (r_state == S_INIT);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.fmt_step = 1'b1;
                if (i_stat.fmt_last) begin
                    o_cmd.fmt_done = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_opcode)
                        OP_ALLOC:  n_state = S_SCAN;
                        OP_FREE:   n_state = S_FREE_RD;
                        OP_FORMAT: n_state = S_FMT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_FMT: begin
                o_cmd.fmt_step = 1'b1;
                if (i_stat.fmt_last) begin
                    o_cmd.fmt_done = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.scan_hit) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_state            = S_DONE;
                end else if (i_stat.scan_end) begin
                    o_cmd.alloc_full = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_FREE_RD: begin
                if (i_stat.free_range_bad) begin
                    o_cmd.free_bad = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (i_stat.free_bit_set) begin
                    o_cmd.free_commit = 1'b1;
                end else begin
                    o_cmd.free_bad = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.load_out) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

FILE: sv/bitmap_block_allocator.sv
// Top level of the bitmap first-fit block allocator.
// Request channel (i_req_valid / o_req_ready) carries one item: opcode and
// block_index. Opcode allocate returns the lowest free block at or above the
// reserved count, free releases a block, format rebuilds the map.
// Response channel (o_rsp_valid / i_rsp_ready) returns one item per request:
// status, granted_index and the free count after the request.
// Config channel (i_cfg_valid / o_cfg_ready) writes the reserved block count;
// it is ready only while no request is in progress or being offered, and the
// map itself changes only at the next format.
// Allocate scans upward from the word holding the reserved count, one 32-bit
// map word read per cycle from the map RAM; free checks the index range, then
// reads the word and checks its bit; format writes one RAM word per cycle; an
// unused opcode returns status OK with no map access. One request is in flight
// at a time; the next one is accepted only after the response has been loaded.
// After reset the block sweeps all 128 map words with the reset reserve and
// holds o_req_ready low meanwhile; config writes are taken.
// A finished response waits in an output register; the next request is
// accepted meanwhile and its result is held until the receiver takes the
// previous one.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [RES_W-1:0]  i_reserved_blocks,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [IDX_W-1:0]  i_block_index,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_granted_index,
    output logic [CNT_W-1:0]  o_free_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_cfg_ready (o_cfg_ready),
        .i_opcode    (i_opcode),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bba_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_res       (i_reserved_blocks),
        .i_opcode        (i_opcode),
        .i_block_index   (i_block_index),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_count    (o_free_count)
    );

endmodule

FILE: tb/tb_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_block_allocator: directed table, then random phases.
module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int STALL_MAX    = 19;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 140;

    // One response item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  granted;
        logic [CNT_W-1:0]  count;
    } t_alloc_rsp;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // Directed row: request or reserve write, answer typed in where obvious
    typedef struct packed {
        t_row_kind        kind;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] arg;
        logic             typed;
        t_alloc_rsp       rsp;
    } t_dir_row;

    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // reset state: reserve 18, first grants come right above it
        '{ROW_REQ, OP_ALLOC,  12'd0,    1'b1, '{STAT_OK,   12'd18,   13'd4077}},
        '{ROW_REQ, OP_ALLOC,  12'd4095, 1'b1, '{STAT_OK,   12'd19,   13'd4076}},
        '{ROW_REQ, OP_FREE,   12'd18,   1'b1, '{STAT_OK,   12'd0,    13'd4077}},
        // double free, reserved block, never-used block
        '{ROW_REQ, OP_FREE,   12'd18,   1'b1, '{STAT_BAD,  12'd0,    13'd4077}},
        '{ROW_REQ, OP_FREE,   12'd17,   1'b1, '{STAT_BAD,  12'd0,    13'd4077}},
        '{ROW_REQ, OP_FREE,   12'd0,    1'b1, '{STAT_BAD,  12'd0,    13'd4077}},
        '{ROW_REQ, OP_FREE,   12'd4095, 1'b1, '{STAT_BAD,  12'd0,    13'd4077}},
        '{ROW_REQ, OP_UNUSED, 12'd4095, 1'b1, '{STAT_OK,   12'd0,    13'd4077}},
        '{ROW_REQ, OP_ALLOC,  12'd2730, 1'b0, '{STAT_OK,   12'd0,    13'd0}},
        // top reserve without format: only the last block is reachable
        '{ROW_CFG, OP_ALLOC,  12'd4095, 1'b0, '{STAT_OK,   12'd0,    13'd0}},
        '{ROW_REQ, OP_ALLOC,  12'd0,    1'b1, '{STAT_OK,   12'd4095, 13'd4075}},
        '{ROW_REQ, OP_ALLOC,  12'd0,    1'b1, '{STAT_FULL, 12'd0,    13'd4075}},
        '{ROW_REQ, OP_FREE,   12'd19,   1'b1, '{STAT_BAD,  12'd0,    13'd4075}},
        '{ROW_REQ, OP_FREE,   12'd4095, 1'b1, '{STAT_OK,   12'd0,    13'd4076}},
        '{ROW_REQ, OP_FORMAT, 12'd1365, 1'b1, '{STAT_OK,   12'd0,    13'd1}},
        '{ROW_REQ, OP_ALLOC,  12'd0,    1'b1, '{STAT_OK,   12'd4095, 13'd0}},
        '{ROW_REQ, OP_ALLOC,  12'd0,    1'b1, '{STAT_FULL, 12'd0,    13'd0}},
        // zero reserve over a full map
        '{ROW_CFG, OP_ALLOC,  12'd0,    1'b0, '{STAT_OK,   12'd0,    13'd0}},
        '{ROW_REQ, OP_FREE,   12'd0,    1'b1, '{STAT_OK,   12'd0,    13'd1}},
        '{ROW_REQ, OP_ALLOC,  12'd0,    1'b0, '{STAT_OK,   12'd0,    13'd0}},
        '{ROW_REQ, OP_FORMAT, 12'd0,    1'b1, '{STAT_OK,   12'd0,    13'd4096}},
        '{ROW_REQ, OP_ALLOC,  12'd2730, 1'b1, '{STAT_OK,   12'd0,    13'd4095}},
        '{ROW_REQ, OP_FREE,   12'd0,    1'b1, '{STAT_OK,   12'd0,    13'd4096}},
        '{ROW_REQ, OP_FREE,   12'd1365, 1'b1, '{STAT_BAD,  12'd0,    13'd4096}},
        '{ROW_CFG, OP_ALLOC,  12'd18,   1'b0, '{STAT_OK,   12'd0,    13'd0}},
        '{ROW_REQ, OP_FORMAT, 12'd0,    1'b0, '{STAT_OK,   12'd0,    13'd0}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [RES_W-1:0]  i_reserved_blocks;
    logic              i_req_valid;
    logic              o_req_ready;
    logic [OP_W-1:0]   i_opcode;
    logic [IDX_W-1:0]  i_block_index;
    logic              o_rsp_valid;
    logic              i_rsp_ready;
    logic [STAT_W-1:0] o_status;
    logic [IDX_W-1:0]  o_granted_index;
    logic [CNT_W-1:0]  o_free_count;

    // Shadow allocator state
    bit [BLOCK_COUNT-1:0] shadow_map;
    int unsigned          shadow_free;
    logic [RES_W-1:0]     shadow_reserve;

    t_alloc_rsp  pending_rsp_q[$];
    int unsigned granted_pool[$];
    int unsigned err_count   = 0;
    int unsigned idle_cycles = 0;

    bitmap_block_allocator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_reserved_blocks (i_reserved_blocks),
        .i_req_valid       (i_req_valid),
        .o_req_ready       (o_req_ready),
        .i_opcode          (i_opcode),
        .i_block_index     (i_block_index),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_free_count      (o_free_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Reserve as the block applies it: clipped to the map size
    function automatic int unsigned clipped_reserve();
        return (shadow_reserve > BLOCK_COUNT) ? BLOCK_COUNT : int'(shadow_reserve);
    endfunction

    function automatic void format_shadow();
        int unsigned r;
        r = clipped_reserve();
        shadow_map = '0;
        for (int unsigned b = 0; b < r; b++) shadow_map[b] = 1'b1;
        shadow_free = BLOCK_COUNT - r;
    endfunction

    // Apply one request to the shadow state and return its answer
    function automatic t_alloc_rsp predict_allocation(logic [OP_W-1:0] op,
                                                      logic [IDX_W-1:0] idx);
        t_alloc_rsp  r;
        int unsigned b;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_ALLOC: begin
                b = clipped_reserve();
                while (b < BLOCK_COUNT && shadow_map[b]) b++;
                if (b < BLOCK_COUNT) begin
                    shadow_map[b] = 1'b1;
                    if (shadow_free > 0) shadow_free--;
                    r.granted = IDX_W'(b);
                    granted_pool.push_back(b);
                end else begin
                    r.status = STAT_FULL;
                end
            end
            OP_FREE: begin
                if (idx < clipped_reserve() || idx >= BLOCK_COUNT || !shadow_map[idx]) begin
                    r.status = STAT_BAD;
                end else begin
                    shadow_map[idx] = 1'b0;
                    if (shadow_free < BLOCK_COUNT) shadow_free++;
                end
            end
            OP_FORMAT: format_shadow();
            default: ;
        endcase
        r.count = CNT_W'(shadow_free);
        return r;
    endfunction

    // Free target: mostly a block handed out earlier, else stray indexes
    function automatic logic [IDX_W-1:0] pick_free_target();
        int unsigned mode;
        int unsigned pos;
        int unsigned v;
        mode = $urandom_range(0, 99);
        if (mode < 60 && granted_pool.size() != 0) begin
            pos = $urandom_range(0, granted_pool.size() - 1);
            v = granted_pool[pos];
            granted_pool.delete(pos);
        end else if (mode < 75) begin
            v = $urandom_range(0, BLOCK_COUNT - 1);
        end else if (mode < 85) begin
            v = $urandom_range(0, shadow_reserve);
        end else begin
            v = $urandom_range(clipped_reserve(), clipped_reserve() + 40);
        end
        return IDX_W'(v);
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // Send one item; typed rows override the predicted answer
    task automatic push_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                logic typed, t_alloc_rsp typed_rsp);
        int unsigned gap;
        t_alloc_rsp  model_rsp;
        gap = $urandom_range(0, STALL_MAX);
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid   <= 1'b1;
        i_opcode      <= op;
        i_block_index <= idx;
        do @(posedge i_clk); while (!o_req_ready);
        model_rsp = predict_allocation(op, idx);
        pending_rsp_q.push_back(typed ? typed_rsp : model_rsp);
    endtask

    // Drop request valid and wait for every outstanding answer
    task automatic settle_requests();
        i_req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reserve(logic [RES_W-1:0] value);
        settle_requests();
        i_cfg_valid       <= 1'b1;
        i_reserved_blocks <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        shadow_reserve  = value;
    endtask

    // Response sink with random stalls, checks each item in order
    initial begin : rsp_sink
        t_alloc_rsp  want;
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, STALL_MAX);
            if (stall != 0) begin
                i_rsp_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (!o_rsp_valid);
            if (pending_rsp_q.size() == 0) begin
                report_mismatch($sformatf("response with nothing pending: status %0d",
                                          o_status));
            end else begin
                want = pending_rsp_q.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_status, want.status));
                if (o_granted_index !== want.granted)
                    report_mismatch($sformatf("granted_index %0d, want %0d",
                                              o_granted_index, want.granted));
                if (o_free_count !== want.count)
                    report_mismatch($sformatf("free_count %0d, want %0d",
                                              o_free_count, want.count));
            end
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[bitmap_block_allocator] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_alloc_rsp       none;
        t_dir_row         row;
        logic [RES_W-1:0] res_val;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        int unsigned      pick;
        none = '0;
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_reserved_blocks <= '0;
        i_req_valid       <= 1'b0;
        i_opcode          <= OP_ALLOC;
        i_block_index     <= '0;
        i_rsp_ready       <= 1'b0;
        shadow_reserve = RESERVED_RESET;
        format_shadow();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int n = 0; n < DIR_ROWS; n++) begin
            row = DIR_TABLE[n];
            if (row.kind == ROW_CFG) write_reserve(row.arg);
            else push_request(row.op, row.arg, row.typed, row.rsp);
        end

        // Random phases, each with its own reserve setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p % 6)
                0:       res_val = '0;
                1:       res_val = RES_W'(4095);
                2:       res_val = RES_W'(RESERVED_RESET);
                3:       res_val = RES_W'($urandom_range(4040, 4095));
                4:       res_val = RES_W'($urandom_range(0, 4095));
                default: res_val = RES_W'($urandom_range(0, 64));
            endcase
            write_reserve(res_val);
            // high reserves stay close to full only right after a format
            if (p % 6 == 3 || $urandom_range(0, 1) == 0)
                push_request(OP_FORMAT, IDX_W'($urandom()), 1'b0, none);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                idx  = IDX_W'($urandom());
                if (pick < 45) begin
                    op = OP_ALLOC;
                end else if (pick < 88) begin
                    op  = OP_FREE;
                    idx = pick_free_target();
                end else if (pick < 93) begin
                    op = OP_FORMAT;
                end else begin
                    op = OP_UNUSED;
                end
                push_request(op, idx, 1'b0, none);
            end
        end

        settle_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_rsp_q.size() == 0) begin
            $display("[bitmap_block_allocator] OK");
        end else begin
            $display("[bitmap_block_allocator] ERROR");
        end
        $finish;
    end

endmodule

FILE: bitmap_block_allocator.f
+incdir+sv
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_datapath.sv
sv/bba_ctrl.sv
sv/bitmap_block_allocator.sv
tb/tb_bitmap_block_allocator.sv
